/* sv/max_diversity_subset_on_circle_macros.svh */
// Assertion macros shared by the checker of the subset search block
`ifndef MAX_DIVERSITY_SUBSET_ON_CIRCLE_MACROS_SVH
`define MAX_DIVERSITY_SUBSET_ON_CIRCLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define MDSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define MDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mdsc_pkg.sv */
// Shared constants, codes and types of the subset search block
package mdsc_pkg;

    localparam int MAX_TAXA    = 64;
    localparam int MAX_SUBSET  = 16;
    localparam int WEIGHT_BITS = 32;

    localparam int POS_W     = $clog2(MAX_TAXA);
    localparam int N_W       = POS_W + 1;
    localparam int LAYER_W   = $clog2(MAX_SUBSET);
    localparam int K_W       = LAYER_W + 1;
    localparam int SCORE_W   = WEIGHT_BITS + LAYER_W + 2;
    localparam int SPAN_W    = N_W + 1;
    localparam int CH_W      = POS_W + 1;
    localparam int CH_DEPTH  = MAX_SUBSET * MAX_TAXA;
    localparam int CH_ADDR_W = LAYER_W + POS_W;
    localparam int TAXON_W   = 6;
    localparam int MODE_W    = 2;
    localparam int CMD_W     = 3;

    localparam logic [CH_W-1:0] CH_NONE = {1'b1, {POS_W{1'b0}}};

    localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TAXON  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    localparam logic [CMD_W-1:0] CMD_NOP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD2  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FINAL  = 3'd5;

    typedef struct packed {
        logic               vld;
        logic [POS_W-1:0]   s;
        logic [SCORE_W-1:0] val;
    } t_tok;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic                   acc_en;
        logic                   sel_tok;
        logic [POS_W-1:0]       u;
        logic [K_W-1:0]         layer;
        logic [N_W-1:0]         n;
        logic                   pw_en;
        logic [POS_W-1:0]       pw_col;
        logic [POS_W-1:0]       pw_row;
        logic [WEIGHT_BITS-1:0] pw_data;
        logic [CH_ADDR_W-1:0]   ch_addr;
    } t_cell_ctl;

endpackage

/* sv/mdsc_ram.sv */
// Generic single-write, single-read RAM with registered read data
module mdsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mdsc_cell.sv */
// One chain cell: owns a pair-value column, a score, a running max and a choice column
module mdsc_cell
    import mdsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [POS_W-1:0] i_pos,
    input  t_cell_ctl        i_ctl,
    input  t_tok             i_left,
    output t_tok             o_tok,
    output logic [CH_W-1:0]  o_choice
);

    t_tok                   r_tok;
    logic [SCORE_W-1:0]     r_prev;
    logic [SCORE_W-1:0]     r_mx;
    logic [CH_W-1:0]        r_arg;
    logic [WEIGHT_BITS-1:0] w_pair_q;
    logic [POS_W-1:0]       w_pair_raddr;
    logic [SCORE_W-1:0]     w_sum;
    logic [SCORE_W-1:0]     w_fin;
    logic                   w_take;
    logic                   w_span_ok;
    logic                   w_fin_ok;
    logic                   w_ch_we;
    logic [CH_W-1:0]        w_ch_wdata;

    assign w_pair_raddr = i_ctl.sel_tok ? i_left.s : i_ctl.u;

    mdsc_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_TAXA)) u_pair_col (
        .i_clk   (i_clk),
        .i_we    (i_ctl.pw_en && (i_ctl.pw_col == i_pos)),
        .i_waddr (i_ctl.pw_row),
        .i_wdata (i_ctl.pw_data),
        .i_raddr (w_pair_raddr),
        .o_rdata (w_pair_q)
    );

    always_comb begin
        w_sum     = r_tok.val + SCORE_W'(w_pair_q);
        w_take    = i_ctl.acc_en && r_tok.vld && (r_tok.s > i_ctl.u)
                    && (w_sum >= r_mx) && (w_sum != '0);
        // layer i entries exist only where v - u >= i - 1
        w_span_ok = SPAN_W'(i_pos) >= (SPAN_W'(i_ctl.u) + SPAN_W'(i_ctl.layer) - SPAN_W'(1));
        w_fin_ok  = w_span_ok && (N_W'(i_pos) < i_ctl.n);
        w_fin     = w_fin_ok ? (r_prev + SCORE_W'(w_pair_q)) : '0;
        w_ch_we   = (i_ctl.cmd == CMD_COMMIT);
        w_ch_wdata = (w_span_ok && (r_mx != '0)) ? r_arg : CH_NONE;
    end

    mdsc_ram #(.WIDTH(CH_W), .DEPTH(CH_DEPTH)) u_choice_col (
        .i_clk   (i_clk),
        .i_we    (w_ch_we),
        .i_waddr (i_ctl.ch_addr),
        .i_wdata (w_ch_wdata),
        .i_raddr (i_ctl.ch_addr),
        .o_rdata (o_choice)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            case (i_ctl.cmd)
                CMD_LOAD2: begin
                    r_prev <= SCORE_W'(w_pair_q);
                end
                CMD_START: begin
                    r_tok <= '{vld: 1'b1, s: i_pos, val: r_prev};
                    r_mx  <= '0;
                    r_arg <= CH_NONE;
                end
                CMD_SHIFT: begin
                    r_tok <= i_left;
                    if (w_take) begin
                        r_mx  <= w_sum;
                        r_arg <= {1'b0, r_tok.s};
                    end
                end
                CMD_COMMIT: begin
                    r_prev <= w_span_ok ? r_mx : '0;
                end
                CMD_FINAL: begin
                    r_tok <= '{vld: 1'b1, s: i_pos, val: w_fin};
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tok = r_tok;

endmodule

/* sv/max_diversity_subset_on_circle.sv */
// Top level: maximum-diversity subset search over a circular taxon order
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_mode i_first_pos i_second_pos
//                                                   i_pair_value i_taxon_id
//   result    out        o_out_valid / i_out_stall  o_chosen_taxon o_last o_no_solution
//   config    in         psel penable pwrite pready paddr pwdata prdata
//
// A search walks every start position u through a chain of 64 cells, one layer
// after another with a token pass across the chain, then traces back the best set
// and emits the result transactions. Reset is synchronous; no clearing pass is needed.
// o_in_stall stays high from search start until the last result is taken;
// a stalled result holds in the output register.
module max_diversity_subset_on_circle
    import mdsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [POS_W-1:0]       i_first_pos,
    input  logic [POS_W-1:0]       i_second_pos,
    input  logic [WEIGHT_BITS-1:0] i_pair_value,
    input  logic [TAXON_W-1:0]     i_taxon_id,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [TAXON_W-1:0]     o_chosen_taxon,
    output logic                   o_last,
    output logic                   o_no_solution,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RD2    = 5'd1;
    localparam logic [4:0] S_LD2    = 5'd2;
    localparam logic [4:0] S_START  = 5'd3;
    localparam logic [4:0] S_PASS   = 5'd4;
    localparam logic [4:0] S_COMMIT = 5'd5;
    localparam logic [4:0] S_RDF    = 5'd6;
    localparam logic [4:0] S_FIN    = 5'd7;
    localparam logic [4:0] S_RED    = 5'd8;
    localparam logic [4:0] S_ROW    = 5'd9;
    localparam logic [4:0] S_TB0    = 5'd10;
    localparam logic [4:0] S_TBRD   = 5'd11;
    localparam logic [4:0] S_TBCHK  = 5'd12;
    localparam logic [4:0] S_FAIL   = 5'd13;
    localparam logic [4:0] S_ERD    = 5'd14;
    localparam logic [4:0] S_EOUT   = 5'd15;
    localparam logic [4:0] S_EHOLD  = 5'd16;

    localparam logic REG_TAXA   = 1'b0;
    localparam logic REG_SUBSET = 1'b1;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TAXA - 1);

    logic [4:0]           r_state;
    logic [N_W-1:0]       r_n;
    logic [K_W-1:0]       r_k;
    logic [POS_W-1:0]     r_u;
    logic [POS_W-1:0]     r_t;
    logic [K_W-1:0]       r_layer;
    logic [SCORE_W-1:0]   r_rb;
    logic [POS_W-1:0]     r_rv;
    logic [SCORE_W-1:0]   r_gbest;
    logic                 r_gvld;
    logic [POS_W-1:0]     r_gl;
    logic [POS_W-1:0]     r_gr;
    logic [POS_W-1:0]     r_cur_v;
    logic [K_W-1:0]       r_j;
    logic [K_W-1:0]       r_cnt;
    logic [K_W-1:0]       r_e;
    logic [POS_W-1:0]     r_path [MAX_SUBSET];
    logic                 r_out_valid;
    logic [TAXON_W-1:0]   r_out_taxon;
    logic                 r_out_last;
    logic                 r_out_nosol;

    logic                 w_in_acc;
    logic                 w_cfg_wr;
    logic [N_W-1:0]       w_n_wr;
    logic [K_W-1:0]       w_k_wr;
    t_cell_ctl            w_ctl;
    t_tok                 w_tok  [MAX_TAXA];
    t_tok                 w_left [MAX_TAXA];
    logic [CH_W-1:0]      w_choice [MAX_TAXA];
    t_tok                 w_tail;
    logic [CH_W-1:0]      w_c;
    logic [TAXON_W-1:0]   w_cyc_q;
    logic [K_W-1:0]       w_lm1;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_tail   = w_tok[MAX_TAXA-1];
    assign w_c      = w_choice[r_cur_v];
    assign w_lm1    = r_layer - K_W'(1);

    // saturate register writes into their legal ranges
    always_comb begin
        w_n_wr = (pwdata[N_W-1:0] > N_W'(MAX_TAXA)) ? N_W'(MAX_TAXA) : pwdata[N_W-1:0];
        if (pwdata[K_W-1:0] < K_W'(2)) begin
            w_k_wr = K_W'(2);
        end else if (pwdata[K_W-1:0] > K_W'(MAX_SUBSET)) begin
            w_k_wr = K_W'(MAX_SUBSET);
        end else begin
            w_k_wr = pwdata[K_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SUBSET) ? 32'(r_k) : 32'(r_n);

    // broadcast command to the whole cell row
    always_comb begin
        w_ctl         = '0;
        w_ctl.cmd     = CMD_NOP;
        w_ctl.u       = r_u;
        w_ctl.layer   = r_layer;
        w_ctl.n       = r_n;
        w_ctl.pw_en   = w_in_acc && (i_mode == MODE_PAIR);
        w_ctl.pw_col  = i_second_pos;
        w_ctl.pw_row  = i_first_pos;
        w_ctl.pw_data = i_pair_value;
        w_ctl.ch_addr = {w_lm1[LAYER_W-1:0], r_u};
        case (r_state)
            S_LD2:    w_ctl.cmd = CMD_LOAD2;
            S_START:  w_ctl.cmd = CMD_START;
            S_PASS: begin
                w_ctl.cmd     = CMD_SHIFT;
                w_ctl.sel_tok = 1'b1;
                w_ctl.acc_en  = (r_t != '0);
            end
            S_COMMIT: w_ctl.cmd = CMD_COMMIT;
            S_FIN: begin
                w_ctl.cmd   = CMD_FINAL;
                w_ctl.layer = r_k;
            end
            S_RED:    w_ctl.cmd = CMD_SHIFT;
            S_TBRD:   w_ctl.ch_addr = {w_lm1[LAYER_W-1:0], r_gl};
            default: begin
            end
        endcase
    end

    // cell row: tokens move one cell toward higher positions each cycle of a shift command
    for (genvar g = 0; g < MAX_TAXA; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '0;
        end else begin : g_body
            assign w_left[g] = w_tok[g-1];
        end
        mdsc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_pos    (POS_W'(g)),
            .i_ctl    (w_ctl),
            .i_left   (w_left[g]),
            .o_tok    (w_tok[g]),
            .o_choice (w_choice[g])
        );
    end

    mdsc_ram #(.WIDTH(TAXON_W), .DEPTH(MAX_TAXA)) u_cycle_order (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (i_mode == MODE_TAXON)),
        .i_waddr (i_first_pos),
        .i_wdata (i_taxon_id),
        .i_raddr (r_path[r_e[LAYER_W-1:0]]),
        .o_rdata (w_cyc_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= N_W'(MAX_TAXA);
            r_k         <= K_W'(2);
            r_out_valid <= 1'b0;
            r_gvld      <= 1'b0;
            r_u         <= '0;
            r_t         <= '0;
            r_layer     <= K_W'(2);
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == REG_TAXA) begin
                    r_n <= w_n_wr;
                end else begin
                    r_k <= w_k_wr;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_mode == MODE_SEARCH)) begin
                        r_u     <= '0;
                        r_gbest <= '0;
                        r_gvld  <= 1'b0;
                        r_state <= S_RD2;
                    end
                end
                S_RD2: begin
                    r_state <= S_LD2;
                end
                S_LD2: begin
                    if (r_k == K_W'(2)) begin
                        r_layer <= K_W'(2);
                        r_state <= S_RDF;
                    end else begin
                        r_layer <= K_W'(3);
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_t     <= '0;
                    r_state <= S_PASS;
                end
                S_PASS: begin
                    r_t <= r_t + POS_W'(1);
                    if (r_t == POS_LAST) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (r_layer == r_k) begin
                        r_state <= S_RDF;
                    end else begin
                        r_layer <= r_layer + K_W'(1);
                        r_state <= S_START;
                    end
                end
                S_RDF: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_rb    <= '0;
                    r_t     <= '0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    // tokens reach the tail in falling v: ties keep the smaller v
                    if (w_tail.vld && (w_tail.val != '0) && (w_tail.val >= r_rb)) begin
                        r_rb <= w_tail.val;
                        r_rv <= w_tail.s;
                    end
                    r_t <= r_t + POS_W'(1);
                    if (r_t == POS_LAST) begin
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (r_rb > r_gbest) begin
                        r_gbest <= r_rb;
                        r_gl    <= r_u;
                        r_gr    <= r_rv;
                        r_gvld  <= 1'b1;
                    end
                    if (r_u == POS_LAST) begin
                        r_state <= S_TB0;
                    end else begin
                        r_u     <= r_u + POS_W'(1);
                        r_state <= S_RD2;
                    end
                end
                S_TB0: begin
                    if (!r_gvld) begin
                        r_state <= S_FAIL;
                    end else begin
                        r_path[0] <= r_gr;
                        r_cur_v   <= r_gr;
                        r_layer   <= r_k;
                        r_j       <= K_W'(1);
                        r_e       <= '0;
                        if (r_k == K_W'(2)) begin
                            r_path[1] <= r_gl;
                            r_cnt     <= K_W'(2);
                            r_state   <= S_ERD;
                        end else begin
                            r_state <= S_TBRD;
                        end
                    end
                end
                S_TBRD: begin
                    r_state <= S_TBCHK;
                end
                S_TBCHK: begin
                    if (w_c[POS_W]) begin
                        r_state <= S_FAIL;
                    end else begin
                        r_path[r_j[LAYER_W-1:0]] <= w_c[POS_W-1:0];
                        if (r_layer == K_W'(3)) begin
                            r_path[r_j[LAYER_W-1:0] + LAYER_W'(1)] <= r_gl;
                            r_cnt   <= r_j + K_W'(2);
                            r_state <= S_ERD;
                        end else begin
                            r_layer <= r_layer - K_W'(1);
                            r_j     <= r_j + K_W'(1);
                            r_cur_v <= w_c[POS_W-1:0];
                            r_state <= S_TBRD;
                        end
                    end
                end
                S_FAIL: begin
                    r_out_taxon <= '0;
                    r_out_last  <= 1'b1;
                    r_out_nosol <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_state     <= S_EHOLD;
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    r_out_taxon <= w_cyc_q;
                    r_out_last  <= (r_e == (r_cnt - K_W'(1)));
                    r_out_nosol <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_EHOLD;
                end
                S_EHOLD: begin
                    // hold the transaction until the sink takes it
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_e     <= r_e + K_W'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_chosen_taxon = r_out_taxon;
    assign o_last         = r_out_last;
    assign o_no_solution  = r_out_nosol;

endmodule

/* sv/mdsc_sva.sv */
// Port-level checker of the subset search block and its bind
`include "max_diversity_subset_on_circle_macros.svh"

module mdsc_sva
    import mdsc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [MODE_W-1:0]  i_mode,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [TAXON_W-1:0] o_chosen_taxon,
    input logic               o_last,
    input logic               o_no_solution
);

    `MDSC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_chosen_taxon), "stalled result changed")
    `MDSC_ASSERT_NOW(a_fail_shape, o_out_valid && o_no_solution, o_last && (o_chosen_taxon == '0), "failure result malformed")
    `MDSC_ASSERT_NOW(a_busy_out, o_out_valid, o_in_stall, "result pending while input open")
    `MDSC_ASSERT_NEXT(a_search_busy, i_in_valid && !o_in_stall && (i_mode == MODE_SEARCH), o_in_stall, "search did not close input")

endmodule

bind max_diversity_subset_on_circle mdsc_sva u_mdsc_sva (.*);

/* bench/tb.sv */
// Testbench for the circular maximum-diversity subset search block
`timescale 1ns / 1ps

module tb;
    import mdsc_pkg::*;

    // Search the chain for the best set of k taxa, then trace back from the winning pair
    localparam int NONE_POS   = -1;
    localparam int WATCH_MAX  = 400000;
    localparam int HOLD_LEN   = 400;
    localparam logic [2:0] ADDR_TAXA   = 3'd0;
    localparam logic [2:0] ADDR_SUBSET = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]      mode;
        logic [POS_W-1:0]       u;
        logic [POS_W-1:0]       v;
        logic [WEIGHT_BITS-1:0] val;
        logic [TAXON_W-1:0]     tax;
    } t_item;

    typedef struct {
        logic [TAXON_W-1:0] taxon;
        logic               last;
        logic               nosol;
    } t_pick;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [MODE_W-1:0]      i_mode = '0;
    logic [POS_W-1:0]       i_first_pos = '0;
    logic [POS_W-1:0]       i_second_pos = '0;
    logic [WEIGHT_BITS-1:0] i_pair_value = '0;
    logic [TAXON_W-1:0]     i_taxon_id = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [TAXON_W-1:0]     o_chosen_taxon;
    logic                   o_last;
    logic                   o_no_solution;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    max_diversity_subset_on_circle uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow state of the block
    longint unsigned pair_tab [MAX_TAXA][MAX_TAXA];
    logic [TAXON_W-1:0] cyc_tab [MAX_TAXA];
    longint unsigned lay_prev [MAX_TAXA][MAX_TAXA];
    longint unsigned lay_cur [MAX_TAXA][MAX_TAXA];
    int choice_tab [MAX_SUBSET][MAX_TAXA][MAX_TAXA];
    int taxa_n = MAX_TAXA;
    int subset_k = 2;

    t_item pending_q[$];
    t_pick picks_q[$];

    int send_idle = 0;
    int recv_idle = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int searches = 0;
    int failed_sets = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    task automatic push_fail();
        t_pick p;
        p.taxon = '0;
        p.last  = 1'b1;
        p.nosol = 1'b1;
        picks_q = {picks_q, p};
        failed_sets++;
    endtask

    // Layered DP over pairs u<v; first strict maximum wins everywhere
    task automatic predict_subset();
        int n, k, u, v, s, i, c, bu, bv;
        longint unsigned mx, t, best;
        int arg;
        logic [TAXON_W-1:0] ids[$];
        t_pick p;
        n = taxa_n;
        k = subset_k;
        searches++;
        for (u = 0; u < MAX_TAXA; u++)
            for (v = 0; v < MAX_TAXA; v++)
                lay_prev[u][v] = 0;
        for (u = 0; u < n; u++)
            for (v = u + 1; v < n; v++)
                lay_prev[u][v] = pair_tab[u][v];
        for (i = 3; i <= k; i++) begin
            for (u = 0; u < MAX_TAXA; u++)
                for (v = 0; v < MAX_TAXA; v++) begin
                    lay_cur[u][v] = 0;
                    choice_tab[i-1][u][v] = NONE_POS;
                end
            for (u = 0; u <= n - i + 1; u++)
                for (v = u + i - 1; v < n; v++) begin
                    mx = 0;
                    arg = NONE_POS;
                    for (s = u + 1; s < v; s++) begin
                        t = lay_prev[u][s] + pair_tab[s][v];
                        if (t > mx) begin
                            mx = t;
                            arg = s;
                        end
                    end
                    lay_cur[u][v] = mx;
                    choice_tab[i-1][u][v] = arg;
                end
            lay_prev = lay_cur;
        end
        best = 0;
        bu = NONE_POS;
        bv = NONE_POS;
        for (u = 0; u <= n - k + 1; u++)
            for (v = u + k - 1; v < n; v++) begin
                t = lay_prev[u][v] + pair_tab[u][v];
                if (t > best) begin
                    best = t;
                    bu = u;
                    bv = v;
                end
            end
        if (bu == NONE_POS) begin
            push_fail();
            return;
        end
        v = bv;
        ids = {ids, cyc_tab[v]};
        for (i = k; i > 2; i--) begin
            c = choice_tab[i-1][bu][v];
            // traceback hit a cell where no split beat zero
            if (c == NONE_POS) begin
                push_fail();
                return;
            end
            ids = {ids, cyc_tab[c]};
            v = c;
        end
        ids = {ids, cyc_tab[bu]};
        foreach (ids[j]) begin
            p.taxon = ids[j];
            p.last  = (j == ids.size() - 1);
            p.nosol = 1'b0;
            picks_q = {picks_q, p};
        end
    endtask

    task automatic apply_item(input t_item it);
        case (it.mode)
            MODE_PAIR:   pair_tab[it.u][it.v] = {32'b0, it.val};
            MODE_TAXON:  cyc_tab[it.u] = it.tax;
            MODE_SEARCH: predict_subset();
            default: ;
        endcase
    endtask

    // Driver: advance to the next pending item once the current one is taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                apply_item('{i_mode, i_first_pos, i_second_pos, i_pair_value, i_taxon_id});
            if (!i_in_valid || !o_in_stall) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    t_item it;
                    it = pending_q.pop_front();
                    i_mode       <= it.mode;
                    i_first_pos  <= it.u;
                    i_second_pos <= it.v;
                    i_pair_value <= it.val;
                    i_taxon_id   <= it.tax;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expected pick
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (picks_q.size() == 0) begin
                    $display("%0t: unexpected result taxon %0d last %0d no_solution %0d",
                             $time, o_chosen_taxon, o_last, o_no_solution);
                    errors++;
                end else begin
                    t_pick p;
                    p = picks_q.pop_front();
                    if (o_chosen_taxon !== p.taxon) begin
                        $display("%0t: chosen_taxon expected %0d actual %0d",
                                 $time, p.taxon, o_chosen_taxon);
                        errors++;
                    end
                    if (o_last !== p.last) begin
                        $display("%0t: last expected %0d actual %0d", $time, p.last, o_last);
                        errors++;
                    end
                    if (o_no_solution !== p.nosol) begin
                        $display("%0t: no_solution expected %0d actual %0d",
                                 $time, p.nosol, o_no_solution);
                        errors++;
                    end
                end
                // start the long hold-off inside a result burst so the input backs up
                if (hold_reqs != hold_seen) begin
                    hold_seen++;
                    hold_left = HOLD_LEN;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCH_MAX);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TAXA)
            taxa_n = (data[6:0] > MAX_TAXA) ? MAX_TAXA : int'(data[6:0]);
        else
            subset_k = (data[4:0] < 2) ? 2 : (data[4:0] > MAX_SUBSET) ? MAX_SUBSET
                                                                     : int'(data[4:0]);
    endtask

    // Read a register back and compare it with its saturated value
    task automatic check_reg(input logic [2:0] addr, input logic [31:0] exp_val);
        @(posedge i_clk);
        paddr <= addr;
        @(posedge i_clk);
        if (prdata !== exp_val) begin
            $display("%0t: register at %0d expected %0d actual %0d",
                     $time, addr, exp_val, prdata);
            errors++;
        end
    endtask

    function automatic t_item mk(input logic [MODE_W-1:0] m, input int u, input int v,
                                 input logic [31:0] val, input int tax);
        t_item it;
        it.mode = m;
        it.u    = u[POS_W-1:0];
        it.v    = v[POS_W-1:0];
        it.val  = val;
        it.tax  = tax[TAXON_W-1:0];
        return it;
    endfunction

    // style 0: full random, 1: tiny values to force ties, 2: mostly zero
    function automatic logic [31:0] pick_value(input int style);
        case (style)
            1: return $urandom_range(2);
            2: return ($urandom_range(9) == 0) ? $urandom : 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Reload every pair in use, scramble some taxa, add noise, then search
    task automatic queue_phase(input int style, input int nsearch);
        int lim;
        lim = (taxa_n < 2) ? 2 : taxa_n;
        for (int u = 0; u < lim; u++)
            for (int v = u + 1; v < lim; v++)
                pending_q = {pending_q, mk(MODE_PAIR, u, v, pick_value(style), 0)};
        for (int j = 0; j < 4; j++)
            pending_q = {pending_q, mk(MODE_TAXON, $urandom_range(MAX_TAXA - 1), 0, 0,
                                       $urandom_range(63))};
        // reversed pair: stored but never read
        pending_q = {pending_q, mk(MODE_PAIR, $urandom_range(63), 0, $urandom, 0)};
        pending_q = {pending_q, mk(MODE_UNUSED, $urandom_range(63), $urandom_range(63),
                                   $urandom, $urandom_range(63))};
        for (int j = 0; j < nsearch; j++) begin
            pending_q = {pending_q, mk(MODE_SEARCH, $urandom_range(63), $urandom_range(63),
                                       $urandom, $urandom_range(63))};
            if (j + 1 < nsearch)
                for (int r = 0; r < 6; r++)
                    pending_q = {pending_q, mk(MODE_PAIR, $urandom_range(lim - 2), lim - 1,
                                               pick_value(style), 0)};
        end
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_in_valid || picks_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 36;
        recv_idle = 56;

        // Directed: taxa at every position the searches use, extremes of every field
        for (int p = 0; p < 8; p++)
            pending_q = {pending_q, mk(MODE_TAXON, p, 0, 0, (p % 2) ? 63 - p : p)};
        pending_q = {pending_q, mk(MODE_PAIR, 63, 63, 32'hFFFF_FFFF, 0)};
        pending_q = {pending_q, mk(MODE_UNUSED, 63, 63, 32'hFFFF_FFFF, 63)};
        drain();

        // Too few taxa, then k larger than n: both must fail cleanly
        reg_write(ADDR_TAXA, 32'd0);
        reg_write(ADDR_SUBSET, 32'd0);
        pending_q = {pending_q, mk(MODE_SEARCH, 0, 0, 0, 0)};
        drain();
        reg_write(ADDR_TAXA, 32'd3);
        reg_write(ADDR_SUBSET, 32'd5);
        pending_q = {pending_q, mk(MODE_SEARCH, 0, 0, 0, 0)};
        drain();
        reg_write(ADDR_TAXA, 32'd2);
        reg_write(ADDR_SUBSET, 32'd2);
        queue_phase(0, 2);
        drain();

        // Saturating register values, then the longest search walk with k above n
        send_idle = 56;
        recv_idle = 36;
        reg_write(ADDR_TAXA, 32'd127);
        reg_write(ADDR_SUBSET, 32'd31);
        check_reg(ADDR_TAXA, 32'd64);
        check_reg(ADDR_SUBSET, 32'd16);
        reg_write(ADDR_TAXA, 32'd8);
        pending_q = {pending_q, mk(MODE_SEARCH, 0, 0, 0, 0)};
        drain();
        reg_write(ADDR_SUBSET, 32'd4);
        hold_reqs++;
        queue_phase(0, 3);
        drain();
        reg_write(ADDR_TAXA, 32'd6);
        reg_write(ADDR_SUBSET, 32'd6);
        queue_phase(1, 2);
        drain();

        send_idle = 0;
        recv_idle = 0;
        reg_write(ADDR_TAXA, 32'd5);
        reg_write(ADDR_SUBSET, 32'd3);
        queue_phase(2, 3);
        drain();
        reg_write(ADDR_TAXA, 32'd4);
        reg_write(ADDR_SUBSET, 32'd1);
        queue_phase(1, 1);
        drain();

        if (picks_q.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time, picks_q.size());
            errors++;
        end
        $display("Ran %0d searches over 0..8 taxa and k 2..16: %0d results, %0d failed sets",
                 searches, results_seen, failed_sets);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
